@@ hdl/spinor_pkg.sv @@
// ----------------------------------------------------------------------------
// spinor_pkg
// Types, constants and lookup functions for the SPI NOR flash controller.
// ----------------------------------------------------------------------------
package spinor_pkg;

   localparam int FLASH_BYTES  = 4194304;
   localparam int FLASH_AW     = $clog2(FLASH_BYTES);
   localparam int CHIPS        = 2;
   localparam int CHIP_AW      = (CHIPS > 1) ? $clog2(CHIPS) : 1;
   localparam int MEM_AW       = CHIP_AW + FLASH_AW;
   localparam int PAGE_BYTES   = 256;
   localparam int PAGE_AW      = $clog2(PAGE_BYTES);
   localparam int SECTOR_BYTES = 4096;
   localparam int SECTOR_AW    = $clog2(SECTOR_BYTES);

   localparam logic [19:0] GAP_RESET = 20'd50000;

   // register offsets
   localparam logic [11:0] REG_CTRL1  = 12'h000;
   localparam logic [11:0] REG_CTRL2  = 12'h004;
   localparam logic [11:0] REG_STATUS = 12'h008;
   localparam logic [11:0] REG_DATA   = 12'h00C;

   // flash opcodes
   localparam logic [7:0] OP_IDLE  = 8'h00;
   localparam logic [7:0] OP_JEDEC = 8'h9F;
   localparam logic [7:0] OP_RDSR  = 8'h05;
   localparam logic [7:0] OP_ERASE = 8'h20;
   localparam logic [7:0] OP_READ  = 8'h03;
   localparam logic [7:0] OP_WREN  = 8'h06;
   localparam logic [7:0] OP_PROG  = 8'h02;

   localparam logic [7:0] ERASED_BYTE = 8'hFF;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FREAD,
      ST_COMMIT,
      ST_ERASE
   } state_type;

   typedef struct packed {
      logic        req_type;
      logic [11:0] reg_offset;
      logic [31:0] write_data;
      logic [47:0] time_ns;
   } req_pkt_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic        irq_level;
   } rsp_pkt_type;

   function automatic logic [7:0] jedec_id(input logic chip, input logic [1:0] idx);
      logic [7:0] id;
      unique case (idx)
         2'd0:    id = 8'hEF;
         2'd1:    id = 8'h30;
         2'd2:    id = chip ? 8'h16 : 8'h15;
         default: id = 8'hEF;
      endcase
      return id;
   endfunction

endpackage

@@ hdl/spi_controller_with_nor_flash.sv @@
// ----------------------------------------------------------------------------
// spi_controller_with_nor_flash
// Register-level SPI controller in front of NOR flash chips, flash in RAM.
// ----------------------------------------------------------------------------
// Usage:
//  - req channel: one 32-bit register access per request (ctrl1, ctrl2 as
//    chip select, status, data). rsp channel: read data and IRQ level.
//  - csr channel: gap_threshold write, always ready; write only when idle.
//  - The response is registered at the accepting edge. Ordinary accesses
//    sustain one request every cycle while rsp_ready is high.
//  - A data byte of the read-data opcode takes a pass through ST_FREAD for
//    the flash RAM read (synchronous read port).
//  - A page commit walks the page buffer and writes each buffered byte to
//    flash; an empty page writes nothing.
//  - A sector erase writes 4096 bytes.
//  - During these walks req_ready is low.
//  - After reset a clearing pass sets every flash byte to 0xFF, one byte a
//    cycle, CHIPS * FLASH_BYTES bytes (8388608), req_ready low meanwhile.
//  - If rsp_ready is low the result waits in the output register and no
//    new request is taken until it leaves.
// ----------------------------------------------------------------------------
module spi_controller_with_nor_flash (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  spinor_pkg::req_pkt_type  req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output spinor_pkg::rsp_pkt_type  rsp_data,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [19:0]              csr_data
);

   localparam int FAW = spinor_pkg::FLASH_AW;
   localparam int MAW = spinor_pkg::MEM_AW;
   localparam int PAW = spinor_pkg::PAGE_AW;
   localparam int SAW = spinor_pkg::SECTOR_AW;

   // memories
   logic [7:0] flash_mem [spinor_pkg::CHIPS * spinor_pkg::FLASH_BYTES];
   logic [7:0] pbuf_mem  [spinor_pkg::PAGE_BYTES];

   spinor_pkg::state_type state_ff, state_in;

   // architectural registers
   logic [31:0]                     ctrl1_ff, ctrl1_in;
   logic [31:0]                     ctrl2_ff, ctrl2_in;
   logic                            rxne_ff, rxne_in, txe_ff, txe_in, ovr_ff, ovr_in;
   logic [7:0]                      data_out_ff, data_out_in;
   logic [7:0]                      opcode_ff, opcode_in;
   logic [1:0]                      bidx_ff, bidx_in;
   logic [7:0]                      reply_ff, reply_in;
   logic [23:0]                     addr_ff, addr_in;
   logic [FAW-1:0]                  raddr_ff, raddr_in;
   logic [PAW:0]                    plen_ff, plen_in;
   logic [23:0]                     pstart_ff, pstart_in;
   logic [spinor_pkg::CHIPS-1:0]    busy_ff, busy_in;
   logic                            cs_ff, cs_in;
   logic [47:0]                     last_time_ff, last_time_in;
   logic [19:0]                     gap_ff, gap_in;

   // walk control
   logic [MAW-1:0]                  clr_cnt_ff, clr_cnt_in;
   logic [PAW:0]                    ccnt_ff, ccnt_in, clen_ff, clen_in;
   logic [23:0]                     cstart_ff, cstart_in;
   logic                            ccs_ff, ccs_in;
   logic                            pend_ff, pend_in;
   logic [PAW-1:0]                  pidx_ff, pidx_in;
   logic [SAW-1:0]                  ecnt_ff, ecnt_in;
   logic [FAW-SAW-1:0]              ebase_ff, ebase_in;
   logic                            ecs_ff, ecs_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   spinor_pkg::rsp_pkt_type         rsp_data_ff, rsp_data_in;

   // memory ports
   logic                            fl_we;
   logic [MAW-1:0]                  fl_wa, fl_ra;
   logic [7:0]                      fl_wd, fl_rd_ff;
   logic                            pb_we;
   logic [PAW-1:0]                  pb_wa;
   logic [7:0]                      pb_wd, pb_rd_ff;

   logic                            acc;
   logic                            commit_go, erase_go, fread_go;
   logic                            commit_done, erase_done, clear_done;

   function automatic logic [spinor_pkg::CHIP_AW-1:0] CHIP_AW_PAD(input logic c);
      return spinor_pkg::CHIP_AW'(c);
   endfunction

   assign acc         = req_valid && req_ready;
   assign csr_ready   = 1'b1;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_data    = rsp_data_ff;
   assign commit_done = (ccnt_ff >= clen_ff) && !pend_ff;
   assign erase_done  = (ecnt_ff == '1);
   assign clear_done  = (clr_cnt_ff == '1);
   // read port always points at the running address of the selected chip
   assign fl_ra       = {CHIP_AW_PAD(cs_ff), raddr_ff};

   // ------------------------------------------------------------------------
   // request datapath: register effects of one access, decided combinationally;
   // memory walks that follow are started by the *_go pulses
   // ------------------------------------------------------------------------
   always_comb begin
      logic                         gap;
      logic [7:0]                   b;
      logic [7:0]                   op_v;
      logic [1:0]                   bi_v;
      logic [PAW:0]                 pl_v;
      logic [7:0]                   reply_v;
      logic [spinor_pkg::CHIPS-1:0] busy_v;
      logic [23:0]                  addr_v;
      logic [31:0]                  rd;
      logic [47:0]                  dt;

      ctrl1_in     = ctrl1_ff;
      ctrl2_in     = ctrl2_ff;
      rxne_in      = rxne_ff;
      txe_in       = txe_ff;
      ovr_in       = ovr_ff;
      data_out_in  = data_out_ff;
      opcode_in    = opcode_ff;
      bidx_in      = bidx_ff;
      reply_in     = reply_ff;
      addr_in      = addr_ff;
      raddr_in     = raddr_ff;
      plen_in      = plen_ff;
      pstart_in    = pstart_ff;
      busy_in      = busy_ff;
      cs_in        = cs_ff;
      last_time_in = last_time_ff;
      gap_in       = csr_valid ? csr_data : gap_ff;
      clen_in      = clen_ff;
      cstart_in    = cstart_ff;
      ccs_in       = ccs_ff;
      ebase_in     = ebase_ff;
      ecs_in       = ecs_ff;
      commit_go    = 1'b0;
      erase_go     = 1'b0;
      fread_go     = 1'b0;
      pb_we        = 1'b0;
      pb_wa        = plen_ff[PAW-1:0];
      pb_wd        = req_data.write_data[7:0];
      rd           = '0;
      b            = req_data.write_data[7:0];
      dt           = req_data.time_ns - last_time_ff;
      gap          = (req_data.time_ns > last_time_ff) && (dt > {28'd0, gap_ff});
      op_v         = opcode_ff;
      bi_v         = bidx_ff;
      pl_v         = plen_ff;
      reply_v      = reply_ff;
      busy_v       = busy_ff;
      addr_v       = addr_ff;

      if (acc && !req_data.req_type) begin
         priority if (req_data.reg_offset == spinor_pkg::REG_CTRL1) begin
            rd = ctrl1_ff;
         end else if (req_data.reg_offset == spinor_pkg::REG_CTRL2) begin
            rd = ctrl2_ff;
         end else if (req_data.reg_offset == spinor_pkg::REG_STATUS) begin
            rd = {27'd0, ovr_ff, 2'b00, txe_ff, rxne_ff};
         end else if (req_data.reg_offset == spinor_pkg::REG_DATA) begin
            rd      = {24'd0, data_out_ff};
            rxne_in = 1'b0;
         end else begin
            rd = '0;
         end
      end else if (acc) begin
         priority if (req_data.reg_offset == spinor_pkg::REG_CTRL1) begin
            ctrl1_in = req_data.write_data;
         end else if (req_data.reg_offset == spinor_pkg::REG_CTRL2) begin
            ctrl2_in = req_data.write_data;
            // end of transfer: pending page goes out on the old chip
            if (opcode_ff == spinor_pkg::OP_PROG) begin
               commit_go      = 1'b1;
               clen_in        = plen_ff;
               cstart_in      = pstart_ff;
               ccs_in         = cs_ff;
               busy_in[cs_ff] = 1'b0;
               plen_in        = '0;
            end
            opcode_in = spinor_pkg::OP_IDLE;
            bidx_in   = '0;
            reply_in  = '0;
            cs_in     = (spinor_pkg::CHIPS > 1) ? req_data.write_data[0] : 1'b0;
         end else if (req_data.reg_offset == spinor_pkg::REG_STATUS) begin
            if (req_data.write_data[4]) ovr_in = 1'b0;
         end else if (req_data.reg_offset == spinor_pkg::REG_DATA) begin
            last_time_in = req_data.time_ns;
            // time gap: drop the last two bytes and commit
            if (gap && op_v == spinor_pkg::OP_PROG) begin
               commit_go      = 1'b1;
               clen_in        = (pl_v > 2) ? pl_v - (PAW+1)'(2) : '0;
               cstart_in      = pstart_ff;
               ccs_in         = cs_ff;
               busy_v[cs_ff]  = 1'b0;
               pl_v           = '0;
               op_v           = spinor_pkg::OP_IDLE;
               bi_v           = '0;
               reply_v        = '0;
            end
            priority if (op_v == spinor_pkg::OP_IDLE) begin
               op_v    = b;
               bi_v    = '0;
               reply_v = '0;
               if (b == spinor_pkg::OP_WREN) begin
                  op_v = spinor_pkg::OP_IDLE;
               end else if (b == spinor_pkg::OP_PROG) begin
                  pl_v          = '0;
                  busy_v[cs_ff] = 1'b1;
               end
            end else if (op_v == spinor_pkg::OP_JEDEC) begin
               reply_v = spinor_pkg::jedec_id(cs_ff, bi_v);
               bi_v    = bi_v + 2'd1;
               if (bi_v == 2'd3) begin
                  bi_v = '0;
                  op_v = spinor_pkg::OP_IDLE;
               end
            end else if (op_v == spinor_pkg::OP_RDSR) begin
               reply_v = {7'd0, busy_v[cs_ff]};
               op_v    = spinor_pkg::OP_IDLE;
            end else if (op_v == spinor_pkg::OP_PROG) begin
               if (bi_v != 2'd3) begin
                  unique case (bi_v)
                     2'd0:    addr_v = {b, addr_ff[15:0]};
                     2'd1:    addr_v = {addr_ff[23:16], b, addr_ff[7:0]};
                     default: addr_v = {addr_ff[23:8], b};
                  endcase
                  bi_v = bi_v + 2'd1;
                  if (bi_v == 2'd3) begin
                     pstart_in = addr_v;
                     pl_v      = '0;
                  end
               end else begin
                  pb_we   = 1'b1;
                  pb_wa   = pl_v[PAW-1:0];
                  pl_v    = pl_v + (PAW+1)'(1);
                  reply_v = {7'd0, busy_v[cs_ff]};
                  if (pl_v[PAW]) begin
                     // page full
                     commit_go     = 1'b1;
                     clen_in       = pl_v;
                     cstart_in     = pstart_ff;
                     ccs_in        = cs_ff;
                     busy_v[cs_ff] = 1'b0;
                     pl_v          = '0;
                     op_v          = spinor_pkg::OP_IDLE;
                     bi_v          = '0;
                  end
               end
            end else if (op_v == spinor_pkg::OP_READ) begin
               if (bi_v != 2'd3) begin
                  unique case (bi_v)
                     2'd0:    addr_v = {b, addr_ff[15:0]};
                     2'd1:    addr_v = {addr_ff[23:16], b, addr_ff[7:0]};
                     default: addr_v = {addr_ff[23:8], b};
                  endcase
                  bi_v = bi_v + 2'd1;
                  if (bi_v == 2'd3) raddr_in = addr_v[FAW-1:0];
               end else begin
                  // reply comes from the flash RAM next cycle
                  fread_go = 1'b1;
                  raddr_in = raddr_ff + FAW'(1);
               end
            end else if (op_v == spinor_pkg::OP_ERASE) begin
               unique case (bi_v)
                  2'd0:    addr_v = {b, addr_ff[15:0]};
                  2'd1:    addr_v = {addr_ff[23:16], b, addr_ff[7:0]};
                  default: addr_v = {addr_ff[23:8], b};
               endcase
               bi_v = bi_v + 2'd1;
               if (bi_v == 2'd3) begin
                  erase_go      = 1'b1;
                  ebase_in      = addr_v[FAW-1:SAW];
                  ecs_in        = cs_ff;
                  busy_v[cs_ff] = 1'b0;
                  op_v          = spinor_pkg::OP_IDLE;
                  bi_v          = '0;
               end
            end else begin
               // unknown opcode: byte ignored
               op_v = op_v;
            end
            opcode_in   = op_v;
            bidx_in     = bi_v;
            plen_in     = pl_v;
            reply_in    = reply_v;
            busy_in     = busy_v;
            addr_in     = addr_v;
            data_out_in = reply_v;
            ovr_in      = ovr_ff | rxne_ff;
            txe_in      = 1'b1;
            rxne_in     = 1'b1;
         end
      end

      if (state_ff == spinor_pkg::ST_FREAD) begin
         reply_in    = fl_rd_ff;
         data_out_in = fl_rd_ff;
      end

      rsp_data_in.read_data = rd;
      rsp_data_in.irq_level = (ctrl1_in[7] && txe_in) || (ctrl1_in[6] && rxne_in) ||
                              (ctrl1_in[5] && ovr_in);
      if (!acc) rsp_data_in = rsp_data_ff;
      rsp_valid_in = acc || (rsp_valid_ff && !rsp_ready);
   end

   // walk counters
   always_comb begin
      clr_cnt_in = clr_cnt_ff;
      ccnt_in    = ccnt_ff;
      pend_in    = 1'b0;
      pidx_in    = pidx_ff;
      ecnt_in    = ecnt_ff;
      if (state_ff == spinor_pkg::ST_CLEAR) clr_cnt_in = clr_cnt_ff + MAW'(1);
      if (commit_go) begin
         ccnt_in = '0;
      end else if (state_ff == spinor_pkg::ST_COMMIT && ccnt_ff < clen_ff) begin
         pend_in = 1'b1;
         pidx_in = ccnt_ff[PAW-1:0];
         ccnt_in = ccnt_ff + (PAW+1)'(1);
      end
      if (erase_go) ecnt_in = '0;
      else if (state_ff == spinor_pkg::ST_ERASE) ecnt_in = ecnt_ff + SAW'(1);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         spinor_pkg::ST_CLEAR:  if (clear_done) state_in = spinor_pkg::ST_IDLE;
         spinor_pkg::ST_IDLE: begin
            priority if (fread_go)  state_in = spinor_pkg::ST_FREAD;
            else if (commit_go)     state_in = spinor_pkg::ST_COMMIT;
            else if (erase_go)      state_in = spinor_pkg::ST_ERASE;
            else                    state_in = spinor_pkg::ST_IDLE;
         end
         spinor_pkg::ST_FREAD:  state_in = spinor_pkg::ST_IDLE;
         spinor_pkg::ST_COMMIT: if (commit_done) state_in = spinor_pkg::ST_IDLE;
         spinor_pkg::ST_ERASE:  if (erase_done) state_in = spinor_pkg::ST_IDLE;
         default:               state_in = spinor_pkg::ST_IDLE;
      endcase
   end

   // outputs: handshake and flash write port
   always_comb begin
      req_ready = (state_ff == spinor_pkg::ST_IDLE) && (!rsp_valid_ff || rsp_ready);
      fl_we     = 1'b0;
      fl_wa     = '0;
      fl_wd     = spinor_pkg::ERASED_BYTE;
      unique case (state_ff)
         spinor_pkg::ST_CLEAR: begin
            fl_we = 1'b1;
            fl_wa = clr_cnt_ff;
         end
         spinor_pkg::ST_COMMIT: begin
            // wrap inside the page
            fl_we = pend_ff;
            fl_wa = {CHIP_AW_PAD(ccs_ff), cstart_ff[FAW-1:PAW],
                     cstart_ff[PAW-1:0] + pidx_ff};
            fl_wd = pb_rd_ff;
         end
         spinor_pkg::ST_ERASE: begin
            fl_we = 1'b1;
            fl_wa = {CHIP_AW_PAD(ecs_ff), ebase_ff, ecnt_ff};
         end
         default: fl_we = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (fl_we) flash_mem[fl_wa] <= fl_wd;
      fl_rd_ff <= flash_mem[fl_ra];
   end

   always_ff @(posedge clock) begin
      if (pb_we) pbuf_mem[pb_wa] <= pb_wd;
      pb_rd_ff <= pbuf_mem[ccnt_ff[PAW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= spinor_pkg::ST_CLEAR;
         ctrl1_ff     <= '0;
         ctrl2_ff     <= '0;
         rxne_ff      <= 1'b0;
         txe_ff       <= 1'b1;
         ovr_ff       <= 1'b0;
         data_out_ff  <= '0;
         opcode_ff    <= spinor_pkg::OP_IDLE;
         bidx_ff      <= '0;
         reply_ff     <= '0;
         addr_ff      <= '0;
         raddr_ff     <= '0;
         plen_ff      <= '0;
         pstart_ff    <= '0;
         busy_ff      <= '0;
         cs_ff        <= 1'b0;
         last_time_ff <= '0;
         gap_ff       <= spinor_pkg::GAP_RESET;
         clr_cnt_ff   <= '0;
         ccnt_ff      <= '0;
         clen_ff      <= '0;
         pend_ff      <= 1'b0;
         ecnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ctrl1_ff     <= ctrl1_in;
         ctrl2_ff     <= ctrl2_in;
         rxne_ff      <= rxne_in;
         txe_ff       <= txe_in;
         ovr_ff       <= ovr_in;
         data_out_ff  <= data_out_in;
         opcode_ff    <= opcode_in;
         bidx_ff      <= bidx_in;
         reply_ff     <= reply_in;
         addr_ff      <= addr_in;
         raddr_ff     <= raddr_in;
         plen_ff      <= plen_in;
         pstart_ff    <= pstart_in;
         busy_ff      <= busy_in;
         cs_ff        <= cs_in;
         last_time_ff <= last_time_in;
         gap_ff       <= gap_in;
         clr_cnt_ff   <= clr_cnt_in;
         ccnt_ff      <= ccnt_in;
         clen_ff      <= clen_in;
         pend_ff      <= pend_in;
         ecnt_ff      <= ecnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cstart_ff   <= cstart_in;
      ccs_ff      <= ccs_in;
      pidx_ff     <= pidx_in;
      ebase_ff    <= ebase_in;
      ecs_ff      <= ecs_in;
      rsp_data_ff <= rsp_data_in;
   end

   // assertions
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> (state_ff == spinor_pkg::ST_IDLE))
      else $error("request taken outside idle");

   a_commit_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == spinor_pkg::ST_COMMIT) |-> (ccnt_ff <= clen_ff))
      else $error("commit walk past page length");

   a_fread_follows: assert property (@(posedge clock) disable iff (reset)
      fread_go |=> (state_ff == spinor_pkg::ST_FREAD))
      else $error("flash read cycle missing");

   a_single_walk: assert property (@(posedge clock) disable iff (reset)
      acc |-> ($countones({fread_go, commit_go, erase_go}) <= 1))
      else $error("two memory walks started at once");

endmodule

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Checks the SPI NOR flash controller by driving register accesses through the
// request channel and comparing every response, field by field, against a
// behavioral flash model kept inside this testbench. Covers the register set,
// JEDEC ID, status, read data, page program with its three commit causes,
// sector erase, overrun, IRQ enables, and back pressure on both channels.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          CYCLE_LIMIT = 40_000_000;
   localparam logic [31:0] RXNE_BIT    = 32'h01;
   localparam logic [31:0] TXE_BIT     = 32'h02;
   localparam logic [31:0] OVR_BIT     = 32'h10;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   spinor_pkg::req_pkt_type req_data = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   spinor_pkg::rsp_pkt_type rsp_data;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [19:0]             csr_data = '0;

   spi_controller_with_nor_flash dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Flash controller model state
   // ---------------------------------------------------------------------
   logic [19:0] gap_ns;
   logic [31:0] m_ctrl1, m_ctrl2, m_status;
   logic [7:0]  m_dout, m_opcode, m_reply;
   int          m_idx;
   logic [23:0] m_addr, m_run, m_pstart;
   logic [7:0]  m_page [spinor_pkg::PAGE_BYTES];
   int          m_plen;
   logic        m_busy [spinor_pkg::CHIPS];
   logic        m_cs;
   logic [47:0] m_last_t;
   logic [7:0]  flash_img [int];     // absent entries read as erased

   spinor_pkg::rsp_pkt_type resp_q [$];   // responses still owed by the DUT
   int          errors = 0;
   longint      cycles = 0;
   logic [47:0] now_ns = 48'd0;
   bit          quiet = 1'b0;        // no idling on either side
   bit          hold_req = 1'b0;     // ask receiver for a long stall

   function automatic int flash_key(logic chip, logic [23:0] a);
      return int'(chip) * spinor_pkg::FLASH_BYTES + int'(a % spinor_pkg::FLASH_BYTES);
   endfunction

   function automatic logic [7:0] jedec_byte(logic chip, int i);
      logic [7:0] b;
      case (i % 3)
         0: b = 8'hEF;
         1: b = 8'h30;
         default: b = chip ? 8'h16 : 8'h15;
      endcase
      return b;
   endfunction

   function void commit_page();
      logic [23:0] a;
      for (int i = 0; i < m_plen && i < spinor_pkg::PAGE_BYTES; i++) begin
         a = (m_pstart & ~24'(spinor_pkg::PAGE_BYTES - 1)) |
             ((m_pstart + 24'(i)) & 24'(spinor_pkg::PAGE_BYTES - 1));
         flash_img[flash_key(m_cs, a)] = m_page[i];
      end
      m_plen = 0;
      m_busy[m_cs] = 1'b0;
   endfunction

   function void end_transfer();
      if (m_opcode == spinor_pkg::OP_PROG) commit_page();
      m_opcode = spinor_pkg::OP_IDLE;
      m_idx = 0;
      m_reply = 8'h00;
   endfunction

   function void shift_addr(logic [7:0] b);
      case (m_idx)
         0: m_addr[23:16] = b;
         1: m_addr[15:8]  = b;
         default: m_addr[7:0] = b;
      endcase
      m_idx++;
   endfunction

   function void spi_byte(logic [7:0] b, logic [47:0] t);
      logic gap;
      int   base;
      gap = (t > m_last_t) && ((t - m_last_t) > 48'(gap_ns));
      m_last_t = t;
      if (gap && m_opcode == spinor_pkg::OP_PROG) begin
         // time gap: the last two bytes never made it
         m_plen = (m_plen > 2) ? m_plen - 2 : 0;
         end_transfer();
      end
      if (m_opcode == spinor_pkg::OP_IDLE) begin
         m_opcode = b;
         m_idx = 0;
         m_reply = 8'h00;
         if (m_opcode == spinor_pkg::OP_WREN) m_opcode = spinor_pkg::OP_IDLE;
         else if (m_opcode == spinor_pkg::OP_PROG) begin
            m_plen = 0;
            m_busy[m_cs] = 1'b1;
         end
      end else if (m_opcode == spinor_pkg::OP_JEDEC) begin
         m_reply = jedec_byte(m_cs, m_idx);
         m_idx++;
         if (m_idx >= 3) begin
            m_idx = 0;
            m_opcode = spinor_pkg::OP_IDLE;
         end
      end else if (m_opcode == spinor_pkg::OP_RDSR) begin
         m_reply = {7'd0, m_busy[m_cs]};
         m_opcode = spinor_pkg::OP_IDLE;
      end else if (m_opcode == spinor_pkg::OP_PROG) begin
         if (m_idx < 3) begin
            shift_addr(b);
            if (m_idx == 3) begin
               m_run = m_addr;
               m_pstart = m_addr;
               m_plen = 0;
            end
         end else begin
            if (m_plen < spinor_pkg::PAGE_BYTES) m_page[m_plen++] = b;
            m_run = {m_run[23:8], m_run[7:0] + 8'd1};
            m_reply = {7'd0, m_busy[m_cs]};
            if (m_plen >= spinor_pkg::PAGE_BYTES) begin
               commit_page();
               m_opcode = spinor_pkg::OP_IDLE;
               m_idx = 0;
            end
         end
      end else if (m_opcode == spinor_pkg::OP_READ) begin
         if (m_idx < 3) begin
            shift_addr(b);
            if (m_idx == 3) m_run = 24'(m_addr % spinor_pkg::FLASH_BYTES);
         end else begin
            m_run = 24'(m_run % spinor_pkg::FLASH_BYTES);
            m_reply = flash_img.exists(flash_key(m_cs, m_run)) ?
                      flash_img[flash_key(m_cs, m_run)] : spinor_pkg::ERASED_BYTE;
            m_run = 24'((m_run + 24'd1) % spinor_pkg::FLASH_BYTES);
         end
      end else if (m_opcode == spinor_pkg::OP_ERASE) begin
         shift_addr(b);
         if (m_idx >= 3) begin
            base = int'(24'(m_addr % spinor_pkg::FLASH_BYTES) &
                        ~24'(spinor_pkg::SECTOR_BYTES - 1));
            for (int i = 0; i < spinor_pkg::SECTOR_BYTES; i++)
               if (base + i < spinor_pkg::FLASH_BYTES)
                  flash_img.delete(flash_key(m_cs, 24'(base + i)));
            m_busy[m_cs] = 1'b0;
            m_opcode = spinor_pkg::OP_IDLE;
            m_idx = 0;
         end
      end
      m_dout = m_reply;
      if (m_status & RXNE_BIT) m_status |= OVR_BIT;
      m_status |= TXE_BIT | RXNE_BIT;
   endfunction

   function spinor_pkg::rsp_pkt_type predict_access(spinor_pkg::req_pkt_type r);
      spinor_pkg::rsp_pkt_type o;
      o.read_data = '0;
      if (!r.req_type) begin
         case (r.reg_offset)
            spinor_pkg::REG_CTRL1:  o.read_data = m_ctrl1;
            spinor_pkg::REG_CTRL2:  o.read_data = m_ctrl2;
            spinor_pkg::REG_STATUS: o.read_data = m_status;
            spinor_pkg::REG_DATA: begin
               m_status &= ~RXNE_BIT;
               o.read_data = {24'd0, m_dout};
            end
            default: ;
         endcase
      end else begin
         case (r.reg_offset)
            spinor_pkg::REG_CTRL1: m_ctrl1 = r.write_data;
            spinor_pkg::REG_CTRL2: begin
               m_ctrl2 = r.write_data;
               end_transfer();
               m_cs = (spinor_pkg::CHIPS > 1) ? r.write_data[0] : 1'b0;
            end
            spinor_pkg::REG_STATUS: if (r.write_data & OVR_BIT) m_status &= ~OVR_BIT;
            spinor_pkg::REG_DATA:   spi_byte(r.write_data[7:0], r.time_ns);
            default: ;
         endcase
      end
      o.irq_level = (m_ctrl1[7] && (m_status & TXE_BIT) != 0) ||
                    (m_ctrl1[6] && (m_status & RXNE_BIT) != 0) ||
                    (m_ctrl1[5] && (m_status & OVR_BIT) != 0);
      return o;
   endfunction

   // ---------------------------------------------------------------------
   // Response checking
   // ---------------------------------------------------------------------
   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("ERROR @%0t: %s got %h want %h", $realtime, what, got, want);
   endtask

   always @(posedge clock) begin
      spinor_pkg::rsp_pkt_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (resp_q.size() == 0) report("unexpected response", rsp_data.read_data, 32'd0);
         else begin
            want = resp_q.pop_front();
            if (rsp_data.read_data !== want.read_data)
               report("read_data", rsp_data.read_data, want.read_data);
            if (rsp_data.irq_level !== want.irq_level)
               report("irq_level", {31'd0, rsp_data.irq_level}, {31'd0, want.irq_level});
         end
      end
   end

   // Watchdog: covers the post-reset clearing pass plus the whole run.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // Receiver: random stall bursts, plus one long hold on request.
   initial begin
      forever begin
         @(posedge clock);
         if (hold_req) begin
            hold_req = 1'b0;
            rsp_ready <= 1'b0;
            repeat (300) @(posedge clock);
            rsp_ready <= 1'b1;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   // One request; returns after the DUT accepts it.
   task automatic send_access(logic wr, logic [11:0] off, logic [31:0] wd);
      spinor_pkg::req_pkt_type r;
      r.req_type = wr;
      r.reg_offset = off;
      r.write_data = wd;
      r.time_ns = now_ns;
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      resp_q.push_back(predict_access(r));
      now_ns += 48'($urandom_range(1, 300));
   endtask

   task automatic idle_burst();
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   endtask

   task automatic spi_write(logic [7:0] b);
      send_access(1'b1, spinor_pkg::REG_DATA, {24'($urandom()), b});
      idle_burst();
   endtask

   task automatic read_reg(logic [11:0] off);
      send_access(1'b0, off, $urandom());
      idle_burst();
   endtask

   task automatic write_reg(logic [11:0] off, logic [31:0] v);
      send_access(1'b1, off, v);
      idle_burst();
   endtask

   // Data byte followed, usually, by the data read that drains RXNE.
   task automatic xfer(logic [7:0] b);
      spi_write(b);
      if ($urandom_range(0, 7) != 0) read_reg(spinor_pkg::REG_DATA);
   endtask

   task automatic put_address(logic [23:0] a);
      xfer(a[23:16]);
      xfer(a[15:8]);
      xfer(a[7:0]);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (resp_q.size() != 0) @(posedge clock);
   endtask

   // Only once idle: wait out any commit or erase walk, then write.
   task automatic set_gap(logic [19:0] v);
      drain();
      repeat (spinor_pkg::SECTOR_BYTES + 600) @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      gap_ns = v;
   endtask

   function automatic logic [23:0] pick_addr();
      case ($urandom_range(0, 4))
         0: return 24'h000100 + 24'($urandom_range(0, 600));
         1: return 24'h3FFF00 + 24'($urandom_range(0, 255));   // near top
         2: return 24'h400080 + 24'($urandom_range(0, 255));   // wraps
         3: return 24'hFFFF00 + 24'($urandom_range(0, 255));
         default: return 24'($urandom());
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   task automatic test_registers();
      write_reg(spinor_pkg::REG_CTRL1, 32'hFFFF_FFFF);
      read_reg(spinor_pkg::REG_CTRL1);
      write_reg(spinor_pkg::REG_CTRL1, 32'h0000_00E0);
      read_reg(spinor_pkg::REG_STATUS);
      write_reg(12'hFFF, 32'hFFFF_FFFF);      // unmapped offset
      read_reg(12'h00D);                      // near miss on the data offset
   endtask

   task automatic test_ident_and_status();
      write_reg(spinor_pkg::REG_CTRL2, 32'hFFFF_FFFE);    // chip 0, upper bits kept
      xfer(spinor_pkg::OP_JEDEC); xfer(8'h00); xfer(8'h00); xfer(8'h00);
      write_reg(spinor_pkg::REG_CTRL2, 32'h0000_0001);
      xfer(spinor_pkg::OP_JEDEC); xfer(8'hFF); xfer(8'hFF); xfer(8'hFF);
      xfer(spinor_pkg::OP_RDSR); xfer(8'h00);
      xfer(spinor_pkg::OP_WREN);
   endtask

   task automatic test_overrun();
      spi_write(8'h00);
      spi_write(8'h00);                       // RXNE still set: overrun
      read_reg(spinor_pkg::REG_STATUS);
      write_reg(spinor_pkg::REG_STATUS, 32'hFFFF_FFEF);   // no effect
      write_reg(spinor_pkg::REG_STATUS, OVR_BIT);
      read_reg(spinor_pkg::REG_DATA);
   endtask

   task automatic test_program_read();
      write_reg(spinor_pkg::REG_CTRL2, 32'h0);
      xfer(spinor_pkg::OP_PROG); put_address(24'hFFFFFE);   // wraps inside the page
      xfer(8'hA5); xfer(8'h5A); xfer(8'h00); xfer(8'hFF);
      xfer(spinor_pkg::OP_IDLE);              // a payload byte, not an opcode
      write_reg(spinor_pkg::REG_CTRL2, 32'h0);
      xfer(spinor_pkg::OP_READ); put_address(24'hFFFF00);
      repeat (4) xfer(8'h00);
      xfer(8'h77);                            // still inside the read: one more data byte
      write_reg(spinor_pkg::REG_CTRL2, 32'h0);
      xfer(spinor_pkg::OP_ERASE); put_address(24'hFFF123);
      xfer(spinor_pkg::OP_READ); put_address(24'h3FFFFF);
      xfer(8'h00);
      write_reg(spinor_pkg::REG_CTRL2, 32'h0);
   endtask

   task automatic test_gap_commit();
      xfer(spinor_pkg::OP_PROG); put_address(24'h000120);
      repeat (5) xfer(8'($urandom()));
      now_ns += 48'(gap_ns) + 48'd1;          // gap drops the last two bytes
      xfer(spinor_pkg::OP_RDSR);
      now_ns = 48'hFFFF_FFFF_FF00;
      xfer(8'h00);
      now_ns = 48'd10;                        // backwards: no gap
      xfer(spinor_pkg::OP_READ); put_address(24'h000120);
      repeat (3) xfer(8'h00);
      write_reg(spinor_pkg::REG_CTRL2, 32'h0);
   endtask

   // Mostly well-formed flash commands with random content, some noise.
   task automatic test_random(int count);
      int sent;
      int n;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(0, 30) == 0) now_ns = {$urandom(), 16'($urandom())};
         case ($urandom_range(0, 15))
            0: write_reg(spinor_pkg::REG_CTRL1, $urandom());
            1: write_reg(spinor_pkg::REG_CTRL2, $urandom());
            2: write_reg(spinor_pkg::REG_STATUS, $urandom());
            3: read_reg(($urandom_range(0, 3) == 0) ? 12'($urandom()) :
                        12'($urandom_range(0, 3) * 4));
            4: begin
               send_access(1'($urandom_range(0, 1)), 12'($urandom()), $urandom());
               idle_burst();
            end
            5, 6: begin
               xfer(spinor_pkg::OP_JEDEC);
               n = $urandom_range(1, 4);
               repeat (n) xfer(8'($urandom()));
               sent += n;
            end
            7: begin
               xfer(spinor_pkg::OP_RDSR); xfer(8'($urandom()));
               sent++;
            end
            8, 9, 10: begin
               xfer(spinor_pkg::OP_READ); put_address(pick_addr());
               n = $urandom_range(0, 8);
               repeat (n) xfer(8'($urandom()));
               sent += 3 + n;
            end
            11, 12, 13: begin
               xfer(spinor_pkg::OP_PROG); put_address(pick_addr());
               n = ($urandom_range(0, 20) == 0) ? spinor_pkg::PAGE_BYTES :
                                                  $urandom_range(0, 12);
               repeat (n) xfer(8'($urandom()));
               case ($urandom_range(0, 2))
                  0: write_reg(spinor_pkg::REG_CTRL2, $urandom());
                  1: now_ns += 48'(gap_ns) + 48'($urandom_range(1, 1000));
                  default: ;
               endcase
               sent += 3 + n;
            end
            14: begin
               if ($urandom_range(0, 4) == 0) begin
                  xfer(spinor_pkg::OP_ERASE); put_address(pick_addr());
                  sent += 3;
               end else begin
                  xfer(8'($urandom()));         // any opcode, incl. unknown
                  xfer(8'($urandom()));
                  write_reg(spinor_pkg::REG_CTRL2, $urandom());
                  sent += 2;
               end
            end
            default: begin
               xfer(spinor_pkg::OP_WREN);
               if ($urandom_range(0, 3) == 0) now_ns -= 48'($urandom_range(0, 500));
            end
         endcase
         sent++;
      end
   endtask

   // Receiver holds off a long time while requests keep coming.
   task automatic test_backpressure();
      hold_req = 1'b1;
      repeat (40) send_access(1'b0, spinor_pkg::REG_STATUS, 32'h0);
   endtask

   initial begin
      gap_ns = spinor_pkg::GAP_RESET;
      m_ctrl1 = '0; m_ctrl2 = '0; m_status = TXE_BIT;
      m_dout = '0; m_opcode = spinor_pkg::OP_IDLE; m_reply = '0; m_idx = 0;
      m_addr = '0; m_run = '0; m_pstart = '0; m_plen = 0;
      foreach (m_busy[i]) m_busy[i] = 1'b0;
      m_cs = 1'b0; m_last_t = '0;
      foreach (m_page[i]) m_page[i] = '0;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_registers();
      test_ident_and_status();
      test_overrun();
      test_program_read();
      test_gap_commit();
      set_gap(20'd0);
      test_gap_commit();
      test_random(90);
      set_gap(20'd1000000);
      test_random(90);
      test_backpressure();
      set_gap(20'($urandom_range(100, 5000)));
      test_random(110);
      set_gap(spinor_pkg::GAP_RESET);
      quiet = 1'b1;                           // final stretch at full rate
      test_random(70);

      drain();
      repeat (spinor_pkg::SECTOR_BYTES + 600) @(posedge clock);
      if (errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
